@@ hw/rtl/crcw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// CRC-16 word stream checker package
// Shared widths, the CRC polynomial and the request stage record.
// ---------------------------------------------------------------------------
package crcw_pkg;

   localparam int unsigned ByteW = 8;
   localparam int unsigned CrcW  = 16;

   localparam logic [CrcW-1:0] CrcPoly = 16'h1021;

   // One registered request as it waits in the input stage.
   typedef struct packed {
      logic             valid;
      logic             last;
      logic [ByteW-1:0] data;
   } req_stage_type;

endpackage : crcw_pkg
`default_nettype wire

@@ hw/rtl/crcw_absorb.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// CRC word absorb network
// XORs a 16-bit word into the CRC and applies 16 MSB-first shift steps of
// the polynomial as one XOR network.
// ---------------------------------------------------------------------------
module crcw_absorb
   import crcw_pkg::*;
(
   input  wire logic [CrcW-1:0] crc_in,
   input  wire logic [CrcW-1:0] word_in,
   output logic      [CrcW-1:0] crc_out
);

   always_comb begin
      logic [CrcW-1:0] c;
      c = crc_in ^ word_in;
      // The loop is linear in c, so synthesis flattens it into XOR terms.
      for (int k = 0; k < CrcW; k++) begin
         if (c[CrcW-1]) begin
            c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[CrcW-2:0], 1'b0};
         end
      end
      crc_out = c;
   end

endmodule : crcw_absorb
`default_nettype wire

@@ hw/rtl/crcw_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// CRC word stream core
// Pairs bytes into little-endian words, keeps the running CRC and drives
// the result register.
// ---------------------------------------------------------------------------
module crcw_core
   import crcw_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_stage_type   stage_in,
   output logic                 take_out,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic      [CrcW-1:0] rsp_crc_value
);

   logic [CrcW-1:0]  running_crc_ff, running_crc_in;
   logic [ByteW-1:0] held_low_ff, held_low_in;
   logic             have_low_ff, have_low_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CrcW-1:0]  rsp_crc_ff, rsp_crc_in;
   logic [CrcW-1:0]  absorbed_crc;
   logic [CrcW-1:0]  final_crc;
   logic             advance;
   logic             consume;

   crcw_absorb u_absorb (
      .crc_in  (running_crc_ff),
      .word_in ({stage_in.data, held_low_ff}),
      .crc_out (absorbed_crc)
   );

   // The result register moves whenever it is empty or being drained.
   assign advance  = !rsp_valid_ff || rsp_ready;
   assign consume  = stage_in.valid && advance;
   assign take_out = advance;

   assign final_crc = have_low_ff ? absorbed_crc : running_crc_ff;

   always_comb begin
      running_crc_in = running_crc_ff;
      held_low_in    = held_low_ff;
      have_low_in    = have_low_ff;
      if (consume) begin
         if (stage_in.last) begin
            running_crc_in = '0;
            held_low_in    = '0;
            have_low_in    = 1'b0;
         end else if (have_low_ff) begin
            running_crc_in = absorbed_crc;
            held_low_in    = '0;
            have_low_in    = 1'b0;
         end else begin
            held_low_in    = stage_in.data;
            have_low_in    = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_crc_in   = rsp_crc_ff;
      if (advance) begin
         rsp_valid_in = stage_in.valid && stage_in.last;
         rsp_crc_in   = final_crc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff <= '0;
         held_low_ff    <= '0;
         have_low_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         running_crc_ff <= running_crc_in;
         held_low_ff    <= held_low_in;
         have_low_ff    <= have_low_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

`ifndef SYNTH
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      consume && stage_in.last |=> rsp_valid_ff)
      else $error("last request did not produce a result");

   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      consume && stage_in.last |=> !have_low_ff && running_crc_ff == '0)
      else $error("state not cleared after last request");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !have_low_ff)
      else $error("result or held byte present after reset");
`endif

endmodule : crcw_core
`default_nettype wire

@@ hw/rtl/crc16_word_stream_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A request is registered in the input stage, and its result is loaded
// into the result register when that register is empty or being drained.
// Throughput: one request per cycle while the result register is empty or
// being drained, set by the combinational word absorb network between the
// input register and the result register.
// Reset: synchronous, clears the input stage valid bit, running CRC, held
// byte and result valid.
// ---------------------------------------------------------------------------
// CRC-16 word stream checker
// Computes a CRC-16 (polynomial 0x1021, zero start) over little-endian
// 16-bit words built from a byte stream and reports it on the last byte.
// ---------------------------------------------------------------------------
module crc16_word_stream_checker
   import crcw_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [ByteW-1:0] req_data_byte,
   input  wire logic             req_last_byte,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [CrcW-1:0]  rsp_crc_value
);

   req_stage_type stage_ff, stage_in;
   logic          core_take;

   assign req_ready = !stage_ff.valid || core_take;

   always_comb begin
      stage_in = stage_ff;
      if (req_ready) begin
         stage_in.valid = req_valid;
         stage_in.last  = req_last_byte;
         stage_in.data  = req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   crcw_core u_core (
      .clock         (clock),
      .reset         (reset),
      .stage_in      (stage_ff),
      .take_out      (core_take),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_crc_value (rsp_crc_value)
   );

endmodule : crc16_word_stream_checker
`default_nettype wire
